>>> design/ppm_pkg.sv
// Package for the perspective projection matrix block.
// Holds widths, fixed-point constants, the arctangent table, beat types and the
// saturation helpers. It depends on nothing else.
`default_nettype none
package ppm_pkg;

  localparam int unsigned CordicSteps = 16;
  localparam int unsigned QuotW       = 32;
  localparam int unsigned XW          = 34;

  localparam logic signed [XW-1:0] GainQ30   = 34'sd652032874;
  localparam logic        [30:0]   HalfPiQ30 = 31'd1686629713;
  localparam logic        [31:0]   PiQ30     = 32'd3373259426;

  localparam logic [31:0] AtanQ30 [32] = '{
    32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159, 32'd67021687,
    32'd33543516, 32'd16775851, 32'd8388437, 32'd4194283, 32'd2097149,
    32'd1048576, 32'd524288, 32'd262144, 32'd131072, 32'd65536, 32'd32768,
    32'd16384, 32'd8192, 32'd4096, 32'd2048, 32'd1024, 32'd512, 32'd256,
    32'd128, 32'd64, 32'd32, 32'd16, 32'd8, 32'd4, 32'd2, 32'd1, 32'd0
  };

  typedef enum logic [2:0] {
    ST_OK,
    ST_SIN_ZERO,
    ST_ASP_ZERO,
    ST_DEPTH_ZERO,
    ST_SAT
  } status_e;

  typedef struct packed {
    logic        flip;
    logic        fov_zero;
    logic [23:0] aspect;
    logic [31:0] near_plane;
    logic [31:0] far_plane;
  } cord_side_t;

  typedef struct packed {
    status_e     status;
    logic        neg_c;
    logic        neg_d;
    logic [31:0] near_plane;
  } div_side_t;

  typedef struct packed {
    logic [31:0] scale_x;
    logic [31:0] scale_y;
    logic [31:0] depth_scale;
    logic [31:0] depth_offset;
    status_e     status;
  } result_t;

  function automatic logic [31:0] sat_value(input logic [47:0] m, input logic neg);
    logic [31:0] r;
    if (neg) begin
      r = (m > 48'h0000_8000_0000) ? 32'h8000_0000 : (~m[31:0] + 32'd1);
    end else begin
      r = (m > 48'h0000_7FFF_FFFF) ? 32'h7FFF_FFFF : m[31:0];
    end
    return r;
  endfunction

  function automatic logic sat_hit(input logic [47:0] m, input logic neg);
    return neg ? (m > 48'h0000_8000_0000) : (m > 48'h0000_7FFF_FFFF);
  endfunction

endpackage
`default_nettype wire

>>> design/ppm_cordic.sv
// Rotation-mode CORDIC pipeline, one iteration per register stage.
// Depends on ppm_pkg for the gain, the arctangent table and the word width.
`default_nettype none
module ppm_cordic #(
  parameter int unsigned Steps = ppm_pkg::CordicSteps
) (
  input  wire logic                            clk_i,
  input  wire logic                            en_i,
  input  wire logic signed [ppm_pkg::XW-1:0]   z_i,
  output logic signed      [ppm_pkg::XW-1:0]   x_o,
  output logic signed      [ppm_pkg::XW-1:0]   y_o
);

  localparam int unsigned XW = ppm_pkg::XW;

  logic signed [XW-1:0] x_q [Steps];
  logic signed [XW-1:0] y_q [Steps];
  logic signed [XW-1:0] z_q [Steps-1];

  for (genvar i = 0; i < Steps; i++) begin : g_step
    logic signed [XW-1:0] xp, yp, zp, dx, dy, da, x_d, y_d, z_d;

    if (i == 0) begin : g_first
      assign xp = ppm_pkg::GainQ30;
      assign yp = '0;
      assign zp = z_i;
    end else begin : g_next
      assign xp = x_q[i-1];
      assign yp = y_q[i-1];
      assign zp = z_q[i-1];
    end

    assign dx = yp >>> i;
    assign dy = xp >>> i;
    assign da = $signed(XW'(ppm_pkg::AtanQ30[i]));

    always_comb begin
      if (!zp[XW-1]) begin
        x_d = xp - dx;
        y_d = yp + dy;
        z_d = zp - da;
      end else begin
        x_d = xp + dx;
        y_d = yp - dy;
        z_d = zp + da;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[i] <= x_d;
        y_q[i] <= y_d;
      end
    end

    if (i < Steps - 1) begin : g_z
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          z_q[i] <= z_d;
        end
      end
    end
  end

  assign x_o = x_q[Steps-1];
  assign y_o = y_q[Steps-1];

endmodule
`default_nettype wire

>>> design/ppm_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
// Gives the low quotient bits and a flag for a quotient beyond them; uses ppm_pkg.
`default_nettype none
module ppm_div #(
  parameter int unsigned DW = 48,
  parameter int unsigned VW = 33
) (
  input  wire logic                         clk_i,
  input  wire logic                         en_i,
  input  wire logic [DW-1:0]                dividend_i,
  input  wire logic [VW-1:0]                divisor_i,
  output logic      [ppm_pkg::QuotW-1:0]    quot_o,
  output logic                              big_o
);

  localparam int unsigned QW = ppm_pkg::QuotW;
  localparam int unsigned CW = (DW > VW + QW) ? DW : VW + QW;

  logic [DW-1:0] rem_q [QW];
  logic [VW-1:0] dv_q  [QW];
  logic [QW-1:0] q_q   [QW];
  logic          big_q [QW];

  for (genvar j = 0; j < QW; j++) begin : g_bit
    localparam int unsigned K = QW - 1 - j;
    logic [DW-1:0] remp, rem_d;
    logic [VW-1:0] dvp;
    logic [QW-1:0] qp, q_d;
    logic          bigp, fits;
    logic [CW-1:0] trial;

    if (j == 0) begin : g_first
      assign remp = dividend_i;
      assign dvp  = divisor_i;
      assign qp   = '0;
      assign bigp = CW'(dividend_i) >= (CW'(divisor_i) << QW);
    end else begin : g_next
      assign remp = rem_q[j-1];
      assign dvp  = dv_q[j-1];
      assign qp   = q_q[j-1];
      assign bigp = big_q[j-1];
    end

    always_comb begin
      trial  = CW'(dvp) << K;
      fits   = CW'(remp) >= trial;
      rem_d  = fits ? DW'(CW'(remp) - trial) : remp;
      q_d    = qp;
      q_d[K] = fits;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j] <= rem_d;
        dv_q[j]  <= dvp;
        q_q[j]   <= q_d;
        big_q[j] <= bigp;
      end
    end
  end

  assign quot_o = q_q[QW-1];
  assign big_o  = big_q[QW-1];

endmodule
`default_nettype wire

>>> design/perspective_projection_matrix.sv
// Stages from input beat to result beat: one entry stage, one stage per CORDIC iteration,
// a setup stage with the aspect multiplier, 32 divider stages, a saturation stage, a
// multiplier and the output register. A skid register holds one result under back-pressure.
// Throughput: one beat per cycle while the skid register is empty; a full skid stalls all.
// Reset clears all valid bits, the skid and output valid flags among them; no clearing pass.
`default_nettype none
module perspective_projection_matrix #(
  parameter int unsigned CordicSteps = ppm_pkg::CordicSteps
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [14:0] fov_angle_i,
  input  wire logic [23:0] aspect_i,
  input  wire logic [31:0] near_plane_i,
  input  wire logic [31:0] far_plane_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      scale_x_o,
  output logic [31:0]      scale_y_o,
  output logic [31:0]      depth_scale_o,
  output logic [31:0]      depth_offset_o,
  output logic [2:0]       status_o
);

  localparam int unsigned XW = ppm_pkg::XW;
  localparam int unsigned QW = ppm_pkg::QuotW;

  logic en;

  // Entry stage.
  logic [30:0]          t_a;
  logic                 flip_a;
  logic signed [XW-1:0] z_a;
  logic                 a_v_q;
  logic signed [XW-1:0] a_z_q;
  ppm_pkg::cord_side_t  a_side_q;

  always_comb begin
    t_a    = {fov_angle_i, 16'b0};
    flip_a = t_a > ppm_pkg::HalfPiQ30;
    z_a    = flip_a ? $signed(XW'(ppm_pkg::PiQ30) - XW'(t_a)) : $signed(XW'(t_a));
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_z_q               <= z_a;
      a_side_q.flip       <= flip_a;
      a_side_q.fov_zero   <= (fov_angle_i == '0);
      a_side_q.aspect     <= aspect_i;
      a_side_q.near_plane <= near_plane_i;
      a_side_q.far_plane  <= far_plane_i;
    end
  end

  // CORDIC and its side line.
  logic signed [XW-1:0] cx, cy;
  ppm_pkg::cord_side_t  cs_q [CordicSteps];
  logic                 cv_q [CordicSteps];

  ppm_cordic #(.Steps(CordicSteps)) u_cordic (
    .clk_i (clk_i),
    .en_i  (en),
    .z_i   (a_z_q),
    .x_o   (cx),
    .y_o   (cy)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      cs_q[0] <= a_side_q;
      for (int i = 1; i < CordicSteps; i++) begin
        cs_q[i] <= cs_q[i-1];
      end
    end
  end

  // Setup stage.
  ppm_pkg::cord_side_t cs;
  logic [XW-2:0]       cm, sm;
  logic signed [32:0]  diff;
  logic [32:0]         fe, diffm;
  ppm_pkg::status_e    err;
  logic                p_v_q;
  logic [48:0]         p_dy_q;
  logic [64:0]         p_dx_q;
  logic [47:0]         p_dd_q;
  logic [XW-2:0]       p_sm_q;
  logic [56:0]         p_px_q;
  logic [32:0]         p_diffm_q;
  ppm_pkg::div_side_t  p_side_q;

  always_comb begin
    cs    = cs_q[CordicSteps-1];
    cm    = (XW-1)'(cx[XW-1] ? -cx : cx);
    sm    = cy[XW-2:0];
    diff  = $signed({cs.far_plane[31], cs.far_plane})
          - $signed({cs.near_plane[31], cs.near_plane});
    fe    = cs.far_plane[31] ? (33'd0 - {1'b1, cs.far_plane}) : {1'b0, cs.far_plane};
    diffm = diff[32] ? 33'(-diff) : 33'(diff);
    if (cs.fov_zero || cy[XW-1] || (cy == '0)) begin
      err = ppm_pkg::ST_SIN_ZERO;
    end else if (cs.aspect == '0) begin
      err = ppm_pkg::ST_ASP_ZERO;
    end else if (diff == '0) begin
      err = ppm_pkg::ST_DEPTH_ZERO;
    end else begin
      err = ppm_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_dy_q              <= {cm, 16'b0};
      p_dx_q              <= {cm, 32'b0};
      p_dd_q              <= {fe[31:0], 16'b0};
      p_sm_q              <= sm;
      p_px_q              <= 57'(sm * cs.aspect);
      p_diffm_q           <= diffm;
      p_side_q.status     <= err;
      p_side_q.neg_c      <= cx[XW-1] ^ cs.flip;
      p_side_q.neg_d      <= (cs.far_plane[31] != diff[32]) && (cs.far_plane != '0);
      p_side_q.near_plane <= cs.near_plane;
    end
  end

  // Dividers and their side line.
  logic [QW-1:0]      qy, qx, qd;
  logic               by, bx, bd;
  ppm_pkg::div_side_t ds_q [QW];
  logic               dv_q [QW];

  ppm_div #(.DW(49), .VW(XW-1)) u_div_y (
    .clk_i (clk_i), .en_i (en), .dividend_i (p_dy_q), .divisor_i (p_sm_q),
    .quot_o (qy), .big_o (by)
  );

  ppm_div #(.DW(65), .VW(57)) u_div_x (
    .clk_i (clk_i), .en_i (en), .dividend_i (p_dx_q), .divisor_i (p_px_q),
    .quot_o (qx), .big_o (bx)
  );

  ppm_div #(.DW(48), .VW(33)) u_div_d (
    .clk_i (clk_i), .en_i (en), .dividend_i (p_dd_q), .divisor_i (p_diffm_q),
    .quot_o (qd), .big_o (bd)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      ds_q[0] <= p_side_q;
      for (int i = 1; i < QW; i++) begin
        ds_q[i] <= ds_q[i-1];
      end
    end
  end

  // Saturation stage.
  ppm_pkg::div_side_t dsl;
  logic [47:0]        my, mx, md;
  logic               d_v_q, d_sat_q;
  logic [31:0]        d_sx_q, d_sy_q, d_ds_q, d_near_q;
  ppm_pkg::status_e   d_status_q;

  always_comb begin
    dsl = ds_q[QW-1];
    my  = by ? '1 : {16'b0, qy};
    mx  = bx ? '1 : {16'b0, qx};
    md  = bd ? '1 : {16'b0, qd};
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d_sy_q     <= ppm_pkg::sat_value(my, dsl.neg_c);
      d_sx_q     <= ppm_pkg::sat_value(mx, dsl.neg_c);
      d_ds_q     <= ppm_pkg::sat_value(md, dsl.neg_d);
      d_sat_q    <= ppm_pkg::sat_hit(my, dsl.neg_c) | ppm_pkg::sat_hit(mx, dsl.neg_c)
                  | ppm_pkg::sat_hit(md, dsl.neg_d);
      d_near_q   <= dsl.near_plane;
      d_status_q <= dsl.status;
    end
  end

  // Depth offset multiplier.
  logic               m_v_q, m_sat_q;
  logic signed [63:0] m_prod_q;
  logic [31:0]        m_sx_q, m_sy_q, m_ds_q;
  ppm_pkg::status_e   m_status_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_prod_q   <= $signed(d_ds_q) * $signed(d_near_q);
      m_sat_q    <= d_sat_q;
      m_sx_q     <= d_sx_q;
      m_sy_q     <= d_sy_q;
      m_ds_q     <= d_ds_q;
      m_status_q <= d_status_q;
    end
  end

  // Result assembly.
  logic [63:0]      pm;
  logic             negf;
  ppm_pkg::result_t res;

  always_comb begin
    pm   = m_prod_q[63] ? 64'(-m_prod_q) : 64'(m_prod_q);
    negf = !m_prod_q[63] && (m_prod_q != '0);
    if (m_status_q != ppm_pkg::ST_OK) begin
      res        = '0;
      res.status = m_status_q;
    end else begin
      res.scale_x      = m_sx_q;
      res.scale_y      = m_sy_q;
      res.depth_scale  = m_ds_q;
      res.depth_offset = ppm_pkg::sat_value(pm[63:16], negf);
      res.status       = (m_sat_q || ppm_pkg::sat_hit(pm[63:16], negf)) ?
                         ppm_pkg::ST_SAT : ppm_pkg::ST_OK;
    end
  end

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      cv_q  <= '{default: 1'b0};
      p_v_q <= 1'b0;
      dv_q  <= '{default: 1'b0};
      d_v_q <= 1'b0;
      m_v_q <= 1'b0;
    end else if (en) begin
      a_v_q   <= in_valid_i;
      cv_q[0] <= a_v_q;
      for (int i = 1; i < CordicSteps; i++) begin
        cv_q[i] <= cv_q[i-1];
      end
      p_v_q   <= cv_q[CordicSteps-1];
      dv_q[0] <= p_v_q;
      for (int i = 1; i < QW; i++) begin
        dv_q[i] <= dv_q[i-1];
      end
      d_v_q <= dv_q[QW-1];
      m_v_q <= d_v_q;
    end
  end

  // Output register and skid register.
  logic             out_v_q, skid_v_q;
  ppm_pkg::result_t out_q, skid_q;

  assign en         = !skid_v_q;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (out_ready_i) begin
        skid_v_q <= 1'b0;
      end
    end else if (!out_v_q || out_ready_i) begin
      out_v_q <= m_v_q;
    end else if (m_v_q) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (out_ready_i) begin
        out_q <= skid_q;
      end
    end else if (!out_v_q || out_ready_i) begin
      if (m_v_q) begin
        out_q <= res;
      end
    end else if (m_v_q) begin
      skid_q <= res;
    end
  end

  assign out_valid_o    = out_v_q;
  assign scale_x_o      = out_q.scale_x;
  assign scale_y_o      = out_q.scale_y;
  assign depth_scale_o  = out_q.depth_scale;
  assign depth_offset_o = out_q.depth_offset;
  assign status_o       = out_q.status;

  // A held result in the skid register always sits behind a shown one.
  assert property (@(posedge clk_i) disable iff (!rst_ni) skid_v_q |-> out_v_q)
    else $error("skid register full while output is empty");

  // A stalled output with a finished item behind it must park that item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !out_ready_i && !skid_v_q && m_v_q) |=> skid_v_q)
    else $error("finished item lost under back-pressure");

  // Error results carry zero entries.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == ppm_pkg::ST_SIN_ZERO || status_o == ppm_pkg::ST_ASP_ZERO
                     || status_o == ppm_pkg::ST_DEPTH_ZERO))
    |-> (scale_x_o == '0 && scale_y_o == '0 && depth_scale_o == '0 && depth_offset_o == '0))
    else $error("error result with non-zero entries");

endmodule
`default_nettype wire

>>> tb/testbench.sv
// Testbench for the perspective projection matrix block.
// Predicts every result in SystemVerilog and checks it against the output beats.
// Depends on ppm_pkg and the perspective_projection_matrix top level.
`timescale 1ns / 100ps
`default_nettype none
module testbench;

  typedef struct packed {
    logic [14:0] fov;
    logic [23:0] asp;
    logic [31:0] nearp;
    logic [31:0] farp;
  } view_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic [14:0] fov_angle_i = '0;
  logic [23:0] aspect_i = '0;
  logic [31:0] near_plane_i = '0;
  logic [31:0] far_plane_i = '0;
  logic        out_ready_i = 1'b0;
  logic        in_ready_o, out_valid_o;
  logic [31:0] scale_x_o, scale_y_o, depth_scale_o, depth_offset_o;
  logic [2:0]  status_o;

  view_t            pending_views[$];
  ppm_pkg::result_t matrix_expected[$];
  int      errors = 0;
  int      beats_out = 0;
  int      phase = 0;

  perspective_projection_matrix DUT (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic longint fshift(longint v, int k);
    return (v >= 0) ? (v >>> k) : (-((-(v + 1)) >>> k) - 1);
  endfunction

  function automatic logic [31:0] clamp(longint unsigned m, bit neg, ref bit sat);
    if (neg) begin
      if (m > 64'd2147483648) begin
        sat = 1;
        return 32'h8000_0000;
      end
      return 32'(-longint'(m));
    end
    if (m > 64'd2147483647) begin
      sat = 1;
      return 32'h7FFF_FFFF;
    end
    return 32'(m);
  endfunction

  function automatic ppm_pkg::result_t project(view_t v);
    ppm_pkg::result_t r;
    longint t, x, y, z, dx, dy, nv, fv, diff, dsv, prod;
    longint unsigned cm, sm;
    bit flip, sat;
    r = '0;
    r.status = ppm_pkg::ST_OK;
    flip = 0;
    sat = 0;
    nv = longint'($signed(v.nearp));
    fv = longint'($signed(v.farp));
    diff = fv - nv;
    t = longint'(v.fov) << 16;
    if (t > 64'sd1686629713) begin
      flip = 1;
      t = 64'sd3373259426 - t;
    end
    x = 64'sd652032874;
    y = 0;
    z = t;
    for (int i = 0; i < ppm_pkg::CordicSteps && i < 32; i++) begin
      dx = fshift(y, i);
      dy = fshift(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(ppm_pkg::AtanQ30[i]);
      end else begin
        x += dx; y -= dy; z += longint'(ppm_pkg::AtanQ30[i]);
      end
    end
    if (flip) x = -x;
    if (v.fov == 0 || y <= 0) r.status = ppm_pkg::ST_SIN_ZERO;
    else if (v.asp == 0) r.status = ppm_pkg::ST_ASP_ZERO;
    else if (diff == 0) r.status = ppm_pkg::ST_DEPTH_ZERO;
    else begin
      cm = (x < 0) ? longint'(-x) : x;
      sm = y;
      r.scale_y = clamp((cm << 16) / sm, x < 0, sat);
      r.scale_x = clamp((cm << 32) / (sm * v.asp), x < 0, sat);
      r.depth_scale = clamp(((fv < 0 ? -fv : fv) << 16) / (diff < 0 ? -diff : diff),
                            ((fv < 0) != (diff < 0)) && fv != 0, sat);
      dsv = longint'($signed(r.depth_scale));
      prod = dsv * nv;
      r.depth_offset = clamp((prod < 0 ? -prod : prod) >> 16, prod > 0, sat);
      if (sat) r.status = ppm_pkg::ST_SAT;
    end
    return r;
  endfunction

  function automatic view_t random_view();
    view_t v;
    v.fov = $urandom_range(3) == 0 ? 15'($urandom) : 15'($urandom_range(25736, 1));
    v.asp = $urandom_range(7) == 0 ? 24'($urandom_range(3)) : 24'($urandom);
    v.nearp = $urandom_range(3) == 0 ? $urandom : $urandom_range(32'h0010_0000);
    v.farp = $urandom_range(7) == 0 ? v.nearp : $urandom;
    if ($urandom_range(3) == 1) v.farp = v.nearp + $urandom_range(32'h0100_0000, 1);
    return v;
  endfunction

  function automatic bit idle_now(int pct);
    return $urandom_range(99) < pct;
  endfunction

  always @(posedge clk_i) begin
    int pct;
    pct = (phase == 1 || phase == 3) ? 70 : (phase == 4 ? 7 : 0);
    if (in_valid_i && in_ready_o) begin
      matrix_expected.push_back(project({fov_angle_i, aspect_i, near_plane_i, far_plane_i}));
    end
    if (rst_ni && (!in_valid_i || in_ready_o)) begin
      if (pending_views.size() > 0 && !idle_now(pct)) begin
        view_t v;
        v = pending_views.pop_front();
        in_valid_i <= 1'b1;
        fov_angle_i <= v.fov;
        aspect_i <= v.asp;
        near_plane_i <= v.nearp;
        far_plane_i <= v.farp;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    int pct;
    ppm_pkg::result_t e;
    pct = (phase == 2 || phase == 3) ? 70 : (phase == 4 ? 7 : 0);
    if (out_valid_o && out_ready_i) begin
      beats_out++;
      if (matrix_expected.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
      end else begin
        e = matrix_expected.pop_front();
        if (scale_x_o !== e.scale_x) begin
          $error("scale_x expected %h got %h", e.scale_x, scale_x_o); errors++;
        end
        if (scale_y_o !== e.scale_y) begin
          $error("scale_y expected %h got %h", e.scale_y, scale_y_o); errors++;
        end
        if (depth_scale_o !== e.depth_scale) begin
          $error("depth_scale expected %h got %h", e.depth_scale, depth_scale_o); errors++;
        end
        if (depth_offset_o !== e.depth_offset) begin
          $error("depth_offset expected %h got %h", e.depth_offset, depth_offset_o);
          errors++;
        end
        if (status_o !== e.status) begin
          $error("status expected %0d got %0d", e.status, status_o); errors++;
        end
      end
    end
    out_ready_i <= rst_ni && !idle_now(pct);
  end

  initial begin
    view_t v;
    pending_views.push_back({15'd0, 24'h010000, 32'h0001_0000, 32'h0064_0000});
    pending_views.push_back({15'd1, 24'h010000, 32'h0001_0000, 32'h0064_0000});
    pending_views.push_back({15'd25736, 24'h010000, 32'h0001_0000, 32'h0064_0000});
    pending_views.push_back({15'h7FFF, 24'h010000, 32'h0001_0000, 32'h0064_0000});
    pending_views.push_back({15'd12868, 24'h010000, 32'h0001_0000, 32'h0064_0000});
    pending_views.push_back({15'd12869, 24'h018000, 32'h0001_0000, 32'h0064_0000});
    pending_views.push_back({15'd8579, 24'd0, 32'h0001_0000, 32'h0064_0000});
    pending_views.push_back({15'd8579, 24'hFFFFFF, 32'h0001_0000, 32'h0064_0000});
    pending_views.push_back({15'd8579, 24'd1, 32'h0001_0000, 32'h0064_0000});
    pending_views.push_back({15'd8579, 24'h010000, 32'h0005_0000, 32'h0005_0000});
    pending_views.push_back({15'd8579, 24'h010000, 32'h8000_0000, 32'h7FFF_FFFF});
    pending_views.push_back({15'd8579, 24'h010000, 32'h7FFF_FFFF, 32'h8000_0000});
    pending_views.push_back({15'd8579, 24'h010000, 32'h0001_0000, 32'h0001_0001});
    pending_views.push_back({15'd8579, 24'h010000, 32'h7FFF_FFFF, 32'h7FFF_FFFE});
    pending_views.push_back({15'd8579, 24'h010000, 32'hFFFF_0000, 32'h0000_0000});
    pending_views.push_back({15'd8579, 24'h010000, 32'h0000_0000, 32'hFFFF_FFFF});
    pending_views.push_back({15'd8579, 24'h010000, 32'hFFFF_FFFF, 32'h8000_0000});
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int p = 0; p < 5; p++) begin
      phase = p;
      for (int k = 0; k < 306; k++) begin
        v = random_view();
        pending_views.push_back(v);
      end
      while (pending_views.size() > 0 || in_valid_i || matrix_expected.size() > 0)
        @(posedge clk_i);
    end
    repeat (120) @(posedge clk_i);
    $display("Covered %0d result beats over five idling phases.", beats_out);
    if (errors == 0 && matrix_expected.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end
endmodule
`default_nettype wire

>>> files.f
design/ppm_pkg.sv
design/ppm_cordic.sv
design/ppm_div.sv
design/perspective_projection_matrix.sv
tb/testbench.sv
